/* src/kfpf_pkg.sv */
package kfpf_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int ID_W      = 32;
	localparam int DEST_W    = 32;
	localparam int ENTRY_W   = ID_W + DEST_W;
	localparam int COUNT_W   = 6;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 48;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_DROP  = 2'd1,
		ACT_SEND  = 2'd2,
		ACT_FLUSH = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_NO_ROUTE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SUMMARY
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic step;
		logic summary;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic start_scan;
		logic match;
		logic scan_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* src/kfpf_ctrl.sv */
module kfpf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  kfpf_pkg::ctrl_sts_t   sts,
	output kfpf_pkg::ctrl_cmd_t   cmd
);
	import kfpf_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   advance;

	// a matching entry needs the output register; a kept one never waits
	assign advance = !sts.match || sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = sts.start_scan ? S_SCAN : S_SUMMARY;
				end
			end
			S_SCAN: begin
				if (advance && sts.scan_done) begin
					state_next = S_SUMMARY;
				end
			end
			S_SUMMARY: begin
				if (sts.out_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.start   = 1'b0;
		cmd.step    = 1'b0;
		cmd.summary = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_SCAN: begin
				cmd.step = advance;
			end
			S_SUMMARY: begin
				cmd.summary = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* src/kfpf_datapath.sv */
module kfpf_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kfpf_pkg::ctrl_cmd_t             cmd,
	output kfpf_pkg::ctrl_sts_t             sts,
	input  logic [1:0]                      in_action,
	input  logic [kfpf_pkg::ID_W-1:0]       in_packet_id,
	input  logic [kfpf_pkg::DEST_W-1:0]     in_dest_ip,
	input  logic                            in_route_found,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_kind,
	output logic [kfpf_pkg::ID_W-1:0]       out_packet_id,
	output logic                            out_verdict,
	output logic [kfpf_pkg::COUNT_W-1:0]    out_count,
	output logic [kfpf_pkg::STATUS_W-1:0]   out_status,
	output logic [kfpf_pkg::COUNT_W-1:0]    out_queue_length,
	output logic                            out_last
);
	import kfpf_pkg::*;

	logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	action_t             in_act;
	action_t             action_q;
	status_t             status_q;
	logic [DEST_W-1:0]   dest_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    rd_q;
	logic [CNT_W-1:0]    wr_q;
	logic [CNT_W-1:0]    count_q;

	logic                full;
	logic                scan_act;
	logic                we;
	logic [PTR_W-1:0]    waddr;
	logic [ENTRY_W-1:0]  wdata;
	logic                re;
	logic [PTR_W-1:0]    raddr;
	logic                load_verdict;

	logic                out_valid_q;
	logic                out_kind_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_verdict_q;
	logic [COUNT_W-1:0]  out_count_q;
	status_t             out_status_q;
	logic [COUNT_W-1:0]  out_qlen_q;
	logic                out_last_q;

	assign in_act   = action_t'(in_action);
	assign full     = (fill_q >= CNT_W'(QUEUE_DEPTH));
	assign scan_act = (in_act == ACT_DROP) || (in_act == ACT_FLUSH) ||
	                  ((in_act == ACT_SEND) && in_route_found);

	assign sts.start_scan = scan_act && (fill_q != '0);
	assign sts.match      = (action_q == ACT_FLUSH) || (rdata_q[ENTRY_W-1:ID_W] == dest_q);
	assign sts.scan_done  = (rd_q == fill_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign load_verdict = cmd.step && sts.match;

	// one write port: append on add, compact kept entries during a scan
	always_comb begin
		we    = 1'b0;
		waddr = fill_q[PTR_W-1:0];
		wdata = {in_dest_ip, in_packet_id};
		if (cmd.start && (in_act == ACT_ADD) && !full) begin
			we = 1'b1;
		end else if (cmd.step && !sts.match) begin
			we    = 1'b1;
			waddr = wr_q[PTR_W-1:0];
			wdata = rdata_q;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = '0;
		if (cmd.start && sts.start_scan) begin
			re = 1'b1;
		end else if (cmd.step && !sts.scan_done) begin
			re    = 1'b1;
			raddr = rd_q[PTR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			count_q  <= '0;
			action_q <= ACT_ADD;
			status_q <= STAT_OK;
		end else begin
			if (cmd.start) begin
				action_q <= in_act;
				count_q  <= '0;
				rd_q     <= CNT_W'(1);
				if (sts.start_scan) begin
					wr_q <= '0;
				end else if ((in_act == ACT_ADD) && !full) begin
					wr_q <= fill_q + CNT_W'(1);
				end else begin
					wr_q <= fill_q;
				end
				if ((in_act == ACT_ADD) && full) begin
					status_q <= STAT_FULL;
				end else if ((in_act == ACT_SEND) && !in_route_found) begin
					status_q <= STAT_NO_ROUTE;
				end else begin
					status_q <= STAT_OK;
				end
			end
			if (cmd.step) begin
				if (sts.match) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					wr_q <= wr_q + CNT_W'(1);
				end
				if (!sts.scan_done) begin
					rd_q <= rd_q + CNT_W'(1);
				end
			end
			if (cmd.summary) begin
				fill_q <= wr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dest_q <= in_dest_ip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_verdict || cmd.summary) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_verdict) begin
			out_kind_q    <= 1'b0;
			out_id_q      <= rdata_q[ID_W-1:0];
			out_verdict_q <= (action_q != ACT_SEND);
			out_count_q   <= '0;
			out_status_q  <= STAT_OK;
			out_qlen_q    <= '0;
			out_last_q    <= 1'b0;
		end else if (cmd.summary) begin
			out_kind_q    <= 1'b1;
			out_id_q      <= '0;
			out_verdict_q <= 1'b0;
			out_count_q   <= COUNT_W'(count_q);
			out_status_q  <= status_q;
			out_qlen_q    <= COUNT_W'(wr_q);
			out_last_q    <= 1'b1;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_kind         = out_kind_q;
	assign out_packet_id    = out_id_q;
	assign out_verdict      = out_verdict_q;
	assign out_count        = out_count_q;
	assign out_status       = out_status_q;
	assign out_queue_length = out_qlen_q;
	assign out_last         = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fill count above depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.match |-> sts.out_free)
		else $error("verdict loaded over a waiting result");

	a_summary_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.summary |=> out_valid_q && out_kind_q && out_last_q)
		else $error("summary not presented after load");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (wr_q + count_q < rd_q + CNT_W'(1)))
		else $error("compaction pointer ahead of scan");

endmodule

/* src/keyed_flush_packet_fifo.sv */
// Ordered packet buffer with removal by destination key.
//
// Input channel s_*: one item is one action (add, drop by destination,
// send by destination, flush all); accepted when s_tvalid and s_tready are
// both high. Output channel m_*: every action yields zero or more verdict
// items (m_tuser kind 0), one per released entry in arrival order, then one
// summary item (kind 1, m_tlast high) with the count, status and queue length.
//
// An add, a send without route or an action on an empty buffer goes from
// acceptance to the summary, loaded once the output register is free. Drop,
// send and flush read the held entries one per cycle from the entry memory
// unless a match waits for the output register, then load the summary and
// go idle. One action is in work at a time; s_tready is high only while idle.
//
// Receiver stall: results sit in one output register. A scan holds on a
// matching entry until that register is free; entries that stay are compacted
// without waiting. Reset empties the buffer and drops any pending result;
// entry contents are never cleared, since only held slots are read.
module keyed_flush_packet_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// packet_id [31:0], dest_ip [63:32], route_found [64], zero pad [71:65]
	input  logic [kfpf_pkg::S_TDATA_W-1:0]    s_tdata,
	// action [1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_packet_id [31:0], verdict [32], count [38:33], status [40:39],
	// queue_length [46:41], zero pad [47]
	output logic [kfpf_pkg::M_TDATA_W-1:0]    m_tdata,
	// kind [0]
	output logic [0:0]                        m_tuser,
	output logic                              m_tlast
);
	import kfpf_pkg::*;

	ctrl_cmd_t           cmd;
	ctrl_sts_t           sts;
	logic                out_kind;
	logic [ID_W-1:0]     out_packet_id;
	logic                out_verdict;
	logic [COUNT_W-1:0]  out_count;
	logic [STATUS_W-1:0] out_status;
	logic [COUNT_W-1:0]  out_queue_length;

	// sequence actions: accept, scan, summary
	kfpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// entry memory, pointers, counters and output register
	kfpf_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_action        (s_tuser),
		.in_packet_id     (s_tdata[ID_W-1:0]),
		.in_dest_ip       (s_tdata[ID_W+DEST_W-1:ID_W]),
		.in_route_found   (s_tdata[ID_W+DEST_W]),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_kind         (out_kind),
		.out_packet_id    (out_packet_id),
		.out_verdict      (out_verdict),
		.out_count        (out_count),
		.out_status       (out_status),
		.out_queue_length (out_queue_length),
		.out_last         (m_tlast)
	);

	// pack result fields, highest first
	assign m_tdata = {1'b0, out_queue_length, out_status, out_count,
	                  out_verdict, out_packet_id};
	assign m_tuser = out_kind;

endmodule

/* sim/keyed_flush_packet_fifo_test.sv */
`timescale 1ns / 100ps

import kfpf_pkg::*;

// Tracks the held packets as the block should and keeps the results still owed.
class held_packet_board;
	localparam bit KIND_VERDICT   = 1'b0;
	localparam bit KIND_SUMMARY   = 1'b1;
	localparam bit VERDICT_ACCEPT = 1'b0;
	localparam bit VERDICT_DROP   = 1'b1;

	typedef struct {
		bit          kind;
		logic [31:0] packet_id;
		bit          verdict;
		logic [5:0]  count;
		status_t     status;
		logic [5:0]  queue_length;
		bit          last;
	} release_t;

	logic [31:0] held_id[QUEUE_DEPTH];
	logic [31:0] held_dest[QUEUE_DEPTH];
	int          held;
	release_t    owed[$];
	int          errors;

	function new();
		held   = 0;
		errors = 0;
	endfunction

	function int pending();
		return owed.size();
	endfunction

	function void owe(bit kind, logic [31:0] pid, bit verdict, int count, status_t status,
			int qlen);
		release_t r;
		r.kind         = kind;
		r.packet_id    = pid;
		r.verdict      = verdict;
		r.count        = count[5:0];
		r.status       = status;
		r.queue_length = qlen[5:0];
		r.last         = kind;
		owed.push_back(r);
	endfunction

	// Apply one accepted action and queue the verdicts and the summary it yields.
	function void note_action(action_t act, logic [31:0] pid, logic [31:0] dest, bit route);
		status_t st;
		int      freed;
		int      keep;
		st    = STAT_OK;
		freed = 0;
		if (act == ACT_ADD) begin
			if (held >= QUEUE_DEPTH) begin
				st = STAT_FULL;
			end else begin
				held_id[held]   = pid;
				held_dest[held] = dest;
				held++;
			end
		end else if (act == ACT_SEND && !route) begin
			st = STAT_NO_ROUTE;
		end else begin
			keep = 0;
			for (int i = 0; i < held; i++) begin
				if (act == ACT_FLUSH || held_dest[i] == dest) begin
					owe(KIND_VERDICT, held_id[i],
						(act == ACT_SEND) ? VERDICT_ACCEPT : VERDICT_DROP, 0, STAT_OK, 0);
					freed++;
				end else begin
					held_id[keep]   = held_id[i];
					held_dest[keep] = held_dest[i];
					keep++;
				end
			end
			held = keep;
		end
		owe(KIND_SUMMARY, 32'd0, VERDICT_ACCEPT, freed, st, held);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(bit kind, logic [31:0] pid, bit verdict, logic [5:0] count,
			logic [1:0] status, logic [5:0] qlen, bit last);
		release_t r;
		if (owed.size() == 0) begin
			$error("result with nothing owed: kind %0d id 0x%0h", kind, pid);
			errors++;
		end else begin
			r = owed.pop_front();
			compare_field("kind", 32'(r.kind), 32'(kind));
			compare_field("out_packet_id", r.packet_id, pid);
			compare_field("verdict", 32'(r.verdict), 32'(verdict));
			compare_field("count", 32'(r.count), 32'(count));
			compare_field("status", 32'(r.status), 32'(status));
			compare_field("queue_length", 32'(r.queue_length), 32'(qlen));
			compare_field("last", 32'(r.last), 32'(last));
		end
	endfunction
endclass

module keyed_flush_packet_fifo_test;

	localparam int RANDOM_ITEMS = 280;
	localparam int CALM_TAIL    = 50;   // final items run with no idling on either side
	localparam int LONG_HOLD    = 400;  // receiver hold-off, long enough to back up the input
	localparam int DRAIN_CYCLES = 40;   // a full scan plus summary, with margin

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// packet_id [31:0], dest_ip [63:32], route_found [64], zero pad [71:65]
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	// action [1:0]
	logic [1:0]           s_tuser  = ACT_ADD;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// out_packet_id [31:0], verdict [32], count [38:33], status [40:39],
	// queue_length [46:41], zero pad [47]
	logic [M_TDATA_W-1:0] m_tdata;
	// kind [0]
	logic [0:0]           m_tuser;
	logic                 m_tlast;

	held_packet_board board = new();

	bit          calm;           // suppress idling on both sides
	bit          long_hold_req;  // ask the receiver for one long hold-off
	int          items_sent;
	logic [31:0] dest_pool[4];

	keyed_flush_packet_fifo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// Hard stop in case the block hangs or a result never shows up.
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: short random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(1, 7) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check every result that the receiver takes; values are the ones before the edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tuser[0], m_tdata[31:0], m_tdata[32], m_tdata[38:33],
				m_tdata[40:39], m_tdata[46:41], m_tlast);
	end

	// Offer one action, after an optional idle burst; hold it until taken.
	task automatic send_action(action_t act, logic [31:0] pid, logic [31:0] dest, bit route);
		int gap;
		if (!calm && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, route, dest, pid};
		do @(posedge clk); while (!s_tready);
		board.note_action(act, pid, dest, route);
		items_sent++;
	endtask

	// Mostly reuse a few keys so that drop and send find matches.
	function automatic logic [31:0] pick_dest();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return dest_pool[$urandom_range(0, 3)];
	endfunction

	// Weighted mix: adds keep the buffer populated, removals exercise the scan.
	task automatic random_action();
		int      roll;
		action_t act;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			act = ACT_ADD;
		else if (roll < 62)
			act = ACT_DROP;
		else if (roll < 92)
			act = ACT_SEND;
		else
			act = ACT_FLUSH;
		send_action(act, $urandom, pick_dest(), $urandom_range(0, 9) < 7);
	endtask

	initial begin
		int episode;
		int adds;
		int mix;
		int random_goal;

		calm          = 1'b0;
		long_hold_req = 1'b0;
		items_sent    = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty buffer: flush, drop, send with and without route give a bare summary.
		send_action(ACT_FLUSH, 32'd0, 32'd0, 1'b0);
		send_action(ACT_DROP, 32'hFFFF_FFFF, 32'd0, 1'b1);
		send_action(ACT_SEND, 32'd0, 32'hFFFF_FFFF, 1'b0);
		send_action(ACT_SEND, 32'd0, 32'hFFFF_FFFF, 1'b1);
		// Field extremes and a shared key.
		send_action(ACT_ADD, 32'd0, 32'd0, 1'b0);
		send_action(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_action(ACT_ADD, 32'd1, 32'd0, 1'b1);
		send_action(ACT_ADD, 32'd2, 32'hC0A8_0001, 1'b0);
		send_action(ACT_ADD, 32'd3, 32'hFFFF_FFFF, 1'b0);
		// No route: nothing leaves even though entries match.
		send_action(ACT_SEND, 32'd0, 32'd0, 1'b0);
		// Route present: both entries for key zero leave in order.
		send_action(ACT_SEND, 32'hA5A5_A5A5, 32'd0, 1'b1);
		// No matching key, then a drop that matches both entries for key all ones.
		send_action(ACT_DROP, 32'd0, 32'h0001_2345, 1'b1);
		send_action(ACT_DROP, 32'd0, 32'hFFFF_FFFF, 1'b0);
		send_action(ACT_ADD, 32'd4, 32'h0A00_0001, 1'b1);
		send_action(ACT_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

		random_goal = items_sent + RANDOM_ITEMS;
		episode     = 0;
		while (items_sent < random_goal) begin
			foreach (dest_pool[i])
				dest_pool[i] = ($urandom_range(0, 5) == 0) ? {32{i[0]}} : $urandom;
			calm = (episode % 4 == 3) || (items_sent >= random_goal - CALM_TAIL);

			// Every third episode offers 30 to 36 adds, so the buffer often runs past full and adds bounce.
			if (episode % 3 == 0)
				adds = $urandom_range(30, 36);
			else
				adds = $urandom_range(1, 12);
			repeat (adds)
				send_action(ACT_ADD, $urandom, pick_dest(), 1'($urandom_range(0, 1)));

			// Once, after the first burst of adds, stall the receiver and keep offering items.
			if (episode == 0)
				long_hold_req = 1'b1;

			mix = $urandom_range(3, 12);
			repeat (mix)
				random_action();
			episode++;
		end

		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
src/kfpf_pkg.sv
src/kfpf_ctrl.sv
src/kfpf_datapath.sv
src/keyed_flush_packet_fifo.sv
sim/keyed_flush_packet_fifo_test.sv
